// File: hw/rtl/sps_pkg.sv
package sps_pkg;

  // ring depths; each ring holds one entry fewer than its depth
  localparam int RX_DEPTH = 16;
  localparam int TX_DEPTH = 16;
  localparam int RX_AW    = $clog2(RX_DEPTH);
  localparam int TX_AW    = $clog2(TX_DEPTH);

  localparam int OP_W   = 3;
  localparam int BYTE_W = 8;
  localparam int STAT_W = 4;
  localparam int CNT_W  = 4;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [STAT_W-1:0] stat_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // operation codes
  localparam op_t OP_HOST_WR = 3'd0;
  localparam op_t OP_HOST_RD = 3'd1;
  localparam op_t OP_RX_BYTE = 3'd2;
  localparam op_t OP_BREAK   = 3'd3;
  localparam op_t OP_FRAMING = 3'd4;
  localparam op_t OP_OVERRUN = 3'd5;
  localparam op_t OP_TX_POP  = 3'd6;
  localparam op_t OP_SERVICE = 3'd7;

  // status bit positions
  localparam int STAT_FRAMING = 0;
  localparam int STAT_OVERRUN = 1;
  localparam int STAT_BUSY    = 2;
  localparam int STAT_BREAK   = 3;

  // ring push/pop strobes
  typedef struct packed {
    logic  rx_push;
    logic  rx_pop;
    logic  tx_push;
    logic  tx_pop;
    byte_t wdata;
  } ring_ctl_t;

  // ring occupancy, current and after this cycle's strobes
  typedef struct packed {
    logic  rx_vacant;
    logic  rx_full;
    logic  tx_vacant;
    logic  tx_full;
    logic  rx_vacant_nxt;
    logic  tx_vacant_nxt;
    cnt_t  tx_count;
  } ring_stat_t;

  // events for the status block
  typedef struct packed {
    logic  refresh;
    logic  service;
    logic  set_framing;
    logic  set_overrun;
    logic  set_break;
    logic  rx_byte;
    byte_t data;
  } stat_evt_t;

endpackage

// File: hw/rtl/serial_port_fifo_status.sv
// Serial port core: receive and transmit rings plus sticky line status.
// Every command beat (start high, busy low) gives exactly one result beat,
// marked by out_valid for a single cycle, once the command has passed the
// command register and the result register. The receiver cannot stall, so
// results must be captured when out_valid is high. busy is never raised: a
// new command may be issued every cycle, and each one sees the state left by
// the one before it. The ring update and status refresh happen as the command
// moves from the command register into the result register.
module serial_port_fifo_status (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  sps_pkg::op_t   in_op,
  input  sps_pkg::byte_t in_data_byte,
  output logic           out_valid,
  output sps_pkg::byte_t out_read_data,
  output sps_pkg::stat_t out_line_stat,
  output logic           out_rx_ready,
  output sps_pkg::cnt_t  out_tx_count,
  output logic           out_stat_changed,
  output sps_pkg::byte_t out_last_rx_byte
);
  import sps_pkg::*;

  // command register
  logic       cmd_vld_r;
  op_t        cmd_op_r;
  byte_t      cmd_data_r;

  // result register (read data is registered inside the rings)
  logic       res_vld_r;
  logic       res_chg_r;

  ring_ctl_t  ctl;
  ring_stat_t rs;
  stat_evt_t  evt;
  logic       changed;
  byte_t      rd_byte;
  logic       is_wr, is_rd, is_rxb, is_brk, is_frm, is_ovr, is_txp, is_svc;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_vld_r <= 1'b0;
    end else begin
      cmd_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_op_r   <= in_op;
      cmd_data_r <= in_data_byte;
    end
  end

  // decode
  always_comb begin
    is_wr  = 1'b0;
    is_rd  = 1'b0;
    is_rxb = 1'b0;
    is_brk = 1'b0;
    is_frm = 1'b0;
    is_ovr = 1'b0;
    is_txp = 1'b0;
    is_svc = 1'b0;
    if (cmd_vld_r) begin
      unique case (cmd_op_r)
        OP_HOST_WR: is_wr  = 1'b1;
        OP_HOST_RD: is_rd  = 1'b1;
        OP_RX_BYTE: is_rxb = 1'b1;
        OP_BREAK:   is_brk = 1'b1;
        OP_FRAMING: is_frm = 1'b1;
        OP_OVERRUN: is_ovr = 1'b1;
        OP_TX_POP:  is_txp = 1'b1;
        OP_SERVICE: is_svc = 1'b1;
        default:    is_svc = 1'b0;
      endcase
    end
  end

  // ring strobes; full/empty cases simply drop the push or pop
  assign ctl.tx_push = is_wr  && !rs.tx_full;
  assign ctl.rx_pop  = is_rd  && !rs.rx_vacant;
  assign ctl.rx_push = is_rxb && !rs.rx_full;
  assign ctl.tx_pop  = is_txp && !rs.tx_vacant;
  assign ctl.wdata   = cmd_data_r;

  // a dropped host write and a tx pop leave the published status alone
  assign evt.refresh     = ctl.tx_push || is_rd || is_rxb || is_brk || is_frm || is_ovr;
  assign evt.service     = is_svc;
  assign evt.set_framing = is_frm;
  assign evt.set_overrun = is_ovr || (is_rxb && rs.rx_full);
  assign evt.set_break   = is_brk;
  assign evt.rx_byte     = is_rxb;
  assign evt.data        = cmd_data_r;

  sps_rings u_rings (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .rs      (rs),
    .rd_byte (rd_byte)
  );

  sps_status u_status (
    .clk          (clk),
    .rst_n        (rst_n),
    .evt          (evt),
    .rs           (rs),
    .pub_stat     (out_line_stat),
    .pub_rx_ready (out_rx_ready),
    .last_rx_byte (out_last_rx_byte),
    .changed      (changed)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= cmd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    res_chg_r <= changed;
  end

  // status, ready, count and last byte come straight from the state
  // registers, which hold the post-command values during the result beat
  assign out_valid        = res_vld_r;
  assign out_read_data    = rd_byte;
  assign out_stat_changed = res_chg_r;
  assign out_tx_count     = rs.tx_count;

endmodule

// File: hw/rtl/sps_rings.sv
module sps_rings (
  input  logic                clk,
  input  logic                rst_n,
  input  sps_pkg::ring_ctl_t  ctl,
  output sps_pkg::ring_stat_t rs,
  output sps_pkg::byte_t      rd_byte
);
  import sps_pkg::*;

  byte_t            rx_mem [RX_DEPTH];
  byte_t            tx_mem [TX_DEPTH];
  logic [RX_AW-1:0] rx_rd_r, rx_wr_r, rx_rd_inc, rx_wr_inc, rx_rd_nxt, rx_wr_nxt;
  logic [TX_AW-1:0] tx_rd_r, tx_wr_r, tx_rd_inc, tx_wr_inc, tx_rd_nxt, tx_wr_nxt;
  logic [TX_AW:0]   tx_diff;
  byte_t            rdata_r;

  // wrapping increments (depth need not be a power of two)
  assign rx_rd_inc = (rx_rd_r == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_rd_r + 1'b1;
  assign rx_wr_inc = (rx_wr_r == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_wr_r + 1'b1;
  assign tx_rd_inc = (tx_rd_r == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_rd_r + 1'b1;
  assign tx_wr_inc = (tx_wr_r == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_wr_r + 1'b1;

  assign rx_rd_nxt = ctl.rx_pop  ? rx_rd_inc : rx_rd_r;
  assign rx_wr_nxt = ctl.rx_push ? rx_wr_inc : rx_wr_r;
  assign tx_rd_nxt = ctl.tx_pop  ? tx_rd_inc : tx_rd_r;
  assign tx_wr_nxt = ctl.tx_push ? tx_wr_inc : tx_wr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_rd_r <= '0;
      rx_wr_r <= '0;
      tx_rd_r <= '0;
      tx_wr_r <= '0;
    end else begin
      rx_rd_r <= rx_rd_nxt;
      rx_wr_r <= rx_wr_nxt;
      tx_rd_r <= tx_rd_nxt;
      tx_wr_r <= tx_wr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rx_push) begin
      rx_mem[rx_wr_r] <= ctl.wdata;
    end
    if (ctl.tx_push) begin
      tx_mem[tx_wr_r] <= ctl.wdata;
    end
  end

  // registered head read; empty ring reads return zero
  always_ff @(posedge clk) begin
    priority if (ctl.rx_pop) begin
      rdata_r <= rx_mem[rx_rd_r];
    end else if (ctl.tx_pop) begin
      rdata_r <= tx_mem[tx_rd_r];
    end else begin
      rdata_r <= '0;
    end
  end

  always_comb begin
    if (tx_wr_r >= tx_rd_r) begin
      tx_diff = {1'b0, tx_wr_r} - {1'b0, tx_rd_r};
    end else begin
      tx_diff = {1'b0, tx_wr_r} + (TX_AW + 1)'(TX_DEPTH) - {1'b0, tx_rd_r};
    end
  end

  assign rs.rx_vacant     = (rx_rd_r == rx_wr_r);
  assign rs.rx_full       = (rx_wr_inc == rx_rd_r);
  assign rs.tx_vacant     = (tx_rd_r == tx_wr_r);
  assign rs.tx_full       = (tx_wr_inc == tx_rd_r);
  assign rs.rx_vacant_nxt = (rx_rd_nxt == rx_wr_nxt);
  assign rs.tx_vacant_nxt = (tx_rd_nxt == tx_wr_nxt);
  assign rs.tx_count      = CNT_W'(tx_diff);
  assign rd_byte          = rdata_r;

endmodule

// File: hw/rtl/sps_status.sv
module sps_status (
  input  logic               clk,
  input  logic               rst_n,
  input  sps_pkg::stat_evt_t evt,
  input  sps_pkg::ring_stat_t rs,
  output sps_pkg::stat_t     pub_stat,
  output logic               pub_rx_ready,
  output sps_pkg::byte_t     last_rx_byte,
  output logic               changed
);
  import sps_pkg::*;

  logic  framing_r, overrun_r, break_r, rdy_r;
  logic  framing_nxt, overrun_nxt, break_nxt, rdy_nxt;
  stat_t pub_r, pub_nxt, fresh;
  byte_t idr_r, idr_nxt;

  // sticky flags
  assign framing_nxt = framing_r | evt.set_framing;
  assign overrun_nxt = overrun_r | evt.set_overrun;
  assign break_nxt   = break_r   | evt.set_break;
  assign idr_nxt     = evt.rx_byte ? evt.data : idr_r;

  always_comb begin
    fresh               = '0;
    fresh[STAT_FRAMING] = framing_nxt;
    fresh[STAT_OVERRUN] = overrun_nxt;
    fresh[STAT_BUSY]    = !rs.tx_vacant_nxt;
    fresh[STAT_BREAK]   = break_nxt;
  end

  assign pub_nxt = (evt.refresh || evt.service) ? fresh : pub_r;
  assign rdy_nxt = evt.refresh ? !rs.rx_vacant_nxt : rdy_r;
  assign changed = evt.service && (fresh != pub_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      framing_r <= 1'b0;
      overrun_r <= 1'b0;
      break_r   <= 1'b0;
      rdy_r     <= 1'b0;
      pub_r     <= '0;
      idr_r     <= '0;
    end else begin
      framing_r <= framing_nxt;
      overrun_r <= overrun_nxt;
      break_r   <= break_nxt;
      rdy_r     <= rdy_nxt;
      pub_r     <= pub_nxt;
      idr_r     <= idr_nxt;
    end
  end

  assign pub_stat     = pub_r;
  assign pub_rx_ready = rdy_r;
  assign last_rx_byte = idr_r;

endmodule

// File: tb/sps_checker.sv
module sps_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           busy,
  input  sps_pkg::op_t   in_op,
  input  sps_pkg::byte_t in_data_byte,
  input  logic           out_valid,
  input  sps_pkg::byte_t out_read_data,
  input  sps_pkg::stat_t out_line_stat,
  input  logic           out_rx_ready,
  input  sps_pkg::cnt_t  out_tx_count,
  input  logic           out_stat_changed,
  input  sps_pkg::byte_t out_last_rx_byte,
  output int             fail_count,
  output int             pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import sps_pkg::*;

  typedef struct packed {
    byte_t read_data;
    stat_t line_stat;
    logic  rx_ready;
    cnt_t  tx_count;
    logic  stat_changed;
    byte_t last_rx_byte;
  } port_beat_t;

  // shadow copy of the port state
  byte_t rx_ring [RX_DEPTH];
  byte_t tx_ring [TX_DEPTH];
  int    rx_rd, rx_wr, tx_rd, tx_wr;
  logic  framing_flag, overrun_flag, break_flag;
  stat_t pub_stat;
  logic  pub_rx_ready;
  byte_t last_rx;

  port_beat_t expected_port_beats[$];

  function automatic stat_t line_status();
    stat_t s;
    s = '0;
    s[STAT_FRAMING] = framing_flag;
    s[STAT_OVERRUN] = overrun_flag;
    s[STAT_BUSY]    = (tx_rd != tx_wr);
    s[STAT_BREAK]   = break_flag;
    return s;
  endfunction

  task automatic publish_status();
    pub_rx_ready = (rx_rd != rx_wr);
    pub_stat     = line_status();
  endtask

  task automatic apply_port_op(input op_t op, input byte_t b, output port_beat_t r);
    int    nxt;
    stat_t fresh;
    r = '0;
    case (op)
      OP_HOST_WR: begin
        nxt = (tx_wr + 1) % TX_DEPTH;
        // ring full: byte lost, status left alone
        if (nxt != tx_rd) begin
          tx_ring[tx_wr] = b;
          tx_wr = nxt;
          publish_status();
        end
      end
      OP_HOST_RD: begin
        if (rx_rd != rx_wr) begin
          r.read_data = rx_ring[rx_rd];
          rx_rd = (rx_rd + 1) % RX_DEPTH;
        end
        publish_status();
      end
      OP_RX_BYTE: begin
        nxt = (rx_wr + 1) % RX_DEPTH;
        if (nxt == rx_rd) begin
          overrun_flag = 1'b1;
        end else begin
          rx_ring[rx_wr] = b;
          rx_wr = nxt;
        end
        last_rx = b;
        publish_status();
      end
      OP_BREAK: begin
        break_flag = 1'b1;
        publish_status();
      end
      OP_FRAMING: begin
        framing_flag = 1'b1;
        publish_status();
      end
      OP_OVERRUN: begin
        overrun_flag = 1'b1;
        publish_status();
      end
      OP_TX_POP: begin
        // no refresh on a pop
        if (tx_rd != tx_wr) begin
          r.read_data = tx_ring[tx_rd];
          tx_rd = (tx_rd + 1) % TX_DEPTH;
        end
      end
      OP_SERVICE: begin
        fresh = line_status();
        if (fresh != pub_stat) begin
          pub_stat = fresh;
          r.stat_changed = 1'b1;
        end
      end
    endcase
    r.line_stat    = pub_stat;
    r.rx_ready     = pub_rx_ready;
    r.tx_count     = cnt_t'((tx_wr + TX_DEPTH - tx_rd) % TX_DEPTH);
    r.last_rx_byte = last_rx;
  endtask

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    port_beat_t exp_beat;
    if (!rst_n) begin
      rx_rd = 0; rx_wr = 0; tx_rd = 0; tx_wr = 0;
      framing_flag = 1'b0; overrun_flag = 1'b0; break_flag = 1'b0;
      pub_stat = '0; pub_rx_ready = 1'b0; last_rx = '0;
      fail_count = 0;
      expected_port_beats.delete();
    end else begin
      if (start && !busy) begin
        apply_port_op(in_op, in_data_byte, exp_beat);
        expected_port_beats.push_back(exp_beat);
      end
      if (out_valid) begin
        if (expected_port_beats.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          exp_beat = expected_port_beats.pop_front();
          check_field("read_data", int'(exp_beat.read_data), int'(out_read_data));
          check_field("line_stat", int'(exp_beat.line_stat), int'(out_line_stat));
          check_field("rx_ready", int'(exp_beat.rx_ready), int'(out_rx_ready));
          check_field("tx_count", int'(exp_beat.tx_count), int'(out_tx_count));
          check_field("stat_changed", int'(exp_beat.stat_changed),
                      int'(out_stat_changed));
          check_field("last_rx_byte", int'(exp_beat.last_rx_byte),
                      int'(out_last_rx_byte));
        end
      end
    end
    pending_count = expected_port_beats.size();
  end

endmodule

// File: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sps_pkg::*;

  // generous: ~960 beats, half the cycles idle in the slowest phase
  localparam int CYCLE_LIMIT = 100000;
  localparam int PHASE_BEATS = 232;

  logic  clk;
  logic  rst_n;
  logic  start;
  logic  busy;
  op_t   in_op;
  byte_t in_data_byte;
  logic  out_valid;
  byte_t out_read_data;
  stat_t out_line_stat;
  logic  out_rx_ready;
  cnt_t  out_tx_count;
  logic  out_stat_changed;
  byte_t out_last_rx_byte;

  int fail_count;
  int pending_count;
  int cycle_count;

  serial_port_fifo_status i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_read_data    (out_read_data),
    .out_line_stat    (out_line_stat),
    .out_rx_ready     (out_rx_ready),
    .out_tx_count     (out_tx_count),
    .out_stat_changed (out_stat_changed),
    .out_last_rx_byte (out_last_rx_byte)
  );

  sps_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_read_data    (out_read_data),
    .out_line_stat    (out_line_stat),
    .out_rx_ready     (out_rx_ready),
    .out_tx_count     (out_tx_count),
    .out_stat_changed (out_stat_changed),
    .out_last_rx_byte (out_last_rx_byte),
    .fail_count       (fail_count),
    .pending_count    (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result beat ends here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Mostly random bytes, with the all-zero and all-one patterns now and then.
  function automatic byte_t pick_byte();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 8'h00;
    if (sel == 1) return 8'hFF;
    return byte_t'($urandom_range(0, 255));
  endfunction

  // Issue one command beat. Called and returning at a falling edge. While
  // idling, op and data carry junk so that a beat with start low is seen to
  // be ignored. start is left high after the beat; the next call either
  // keeps it up or drops it for an idle cycle.
  task automatic send_beat(input op_t op, input byte_t b, input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start        <= 1'b0;
      in_op        <= op_t'($urandom_range(0, 7));
      in_data_byte <= byte_t'($urandom_range(0, 255));
      @(negedge clk);
    end
    start        <= 1'b1;
    in_op        <= op;
    in_data_byte <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Random traffic as bursts: filling and draining each ring to and past
  // its limits reaches the full-ring drop and the overrun path, and
  // service beats after pops catch the stale busy bit. Line events stay
  // out until allow_events, since their flags never clear.
  task automatic run_phase(input int n_beats, input int idle_pct, input bit allow_events);
    int   sent;
    int   kind;
    int   len;
    op_t  op;
    sent = 0;
    while (sent < n_beats) begin
      kind = $urandom_range(0, 5);
      len  = $urandom_range(1, 20);
      for (int i = 0; i < len && sent < n_beats; i++) begin
        case (kind)
          0: op = OP_HOST_WR;
          1: op = ($urandom_range(0, 3) == 0) ? OP_SERVICE : OP_TX_POP;
          2: op = OP_RX_BYTE;
          3: op = ($urandom_range(0, 4) == 0) ? OP_SERVICE : OP_HOST_RD;
          default: begin
            op = op_t'($urandom_range(0, 7));
            if (!allow_events && (op == OP_BREAK || op == OP_FRAMING || op == OP_OVERRUN))
              op = OP_SERVICE;
          end
        endcase
        send_beat(op, pick_byte(), idle_pct);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_op        = OP_SERVICE;
    in_data_byte = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty-ring reads, byte extremes, pop leaving busy stale
    // until a service beat picks it up.
    send_beat(OP_SERVICE, 8'h00, 0);
    send_beat(OP_HOST_RD, 8'h00, 0);
    send_beat(OP_TX_POP,  8'hFF, 0);
    send_beat(OP_HOST_WR, 8'h00, 0);
    send_beat(OP_HOST_WR, 8'hFF, 0);
    send_beat(OP_SERVICE, 8'h00, 0);
    send_beat(OP_TX_POP,  8'h00, 0);
    send_beat(OP_TX_POP,  8'h00, 0);
    send_beat(OP_TX_POP,  8'h00, 0);
    send_beat(OP_SERVICE, 8'hFF, 0);
    send_beat(OP_RX_BYTE, 8'hFF, 0);
    send_beat(OP_RX_BYTE, 8'h00, 0);
    send_beat(OP_RX_BYTE, 8'hA5, 0);
    send_beat(OP_HOST_RD, 8'h00, 0);
    send_beat(OP_HOST_RD, 8'h00, 0);
    send_beat(OP_HOST_RD, 8'h00, 0);
    send_beat(OP_HOST_RD, 8'h00, 0);
    send_beat(OP_HOST_WR, 8'h5A, 0);
    send_beat(OP_TX_POP,  8'h00, 0);
    send_beat(OP_SERVICE, 8'h00, 0);

    // Random phases: back to back, sender idle about half the time, then
    // idle about a sixth of the time.
    run_phase(PHASE_BEATS, 0,  1'b0);
    run_phase(PHASE_BEATS, 49, 1'b0);
    run_phase(PHASE_BEATS, 17, 1'b0);

    // Sticky line events, each followed by a service beat.
    send_beat(OP_BREAK,   8'h00, 0);
    send_beat(OP_SERVICE, 8'h00, 0);
    send_beat(OP_FRAMING, 8'hFF, 0);
    send_beat(OP_SERVICE, 8'h00, 0);
    send_beat(OP_OVERRUN, 8'h00, 0);
    send_beat(OP_SERVICE, 8'h00, 0);

    run_phase(PHASE_BEATS, 0, 1'b1);

    start <= 1'b0;

    // Drain: every predicted beat back, then a short wait for strays.
    wait (pending_count == 0);
    repeat (4) @(posedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
